@@ src/itl_pkg.sv @@
// shared constants, word layouts and register codes for the icache tag lookup
package itl_pkg;

  localparam int unsigned ADDR_W          = 32;
  localparam int unsigned LAT_W           = 10;
  localparam int unsigned LFSR_W          = 16;
  localparam int unsigned MOD_W           = 4;
  localparam int unsigned NUM_SLOTS       = 4;
  localparam int unsigned FETCH_SLOTS     = 4;
  localparam int unsigned SLOT_STRIDE     = 4;

  localparam int unsigned WAYS_DEF        = 4;
  localparam int unsigned INDEX_BITS_DEF  = 6;
  localparam int unsigned OFFSET_BITS_DEF = 4;

  localparam logic [LAT_W-1:0]  HIT_LAT_RESET  = LAT_W'(1);
  localparam logic [LAT_W-1:0]  MISS_LAT_RESET = LAT_W'(10);
  localparam logic [LFSR_W-1:0] LFSR_SEED      = LFSR_W'(1);
  localparam logic [LFSR_W-1:0] LFSR_MASK      = 16'hB400;

  localparam int unsigned IN_W      = 40;
  localparam int unsigned IN_PAD_W  = IN_W - 2 - ADDR_W;
  localparam int unsigned OUT_W     = 136;
  localparam int unsigned OUT_PAD_W = OUT_W - 2 - NUM_SLOTS * ADDR_W;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = LAT_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HIT_LAT  = 1'b0,
    CFG_MISS_LAT = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [IN_PAD_W-1:0] pad;
    logic [ADDR_W-1:0]   fetch_addr;
    logic                read_valid;
    logic                flush;
  } in_word_t;

  typedef struct packed {
    logic [OUT_PAD_W-1:0]                pad;
    logic [NUM_SLOTS-1:0][ADDR_W-1:0]    slot_address;
    logic                                group_valid;
    logic                                read_ready;
  } out_word_t;

endpackage

@@ src/itl_ram.sv @@
// generic single-write, single-read ram with registered read data
module itl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ src/itl_victim.sv @@
// replacement way selector: 16-bit galois lfsr reduced modulo the way count
module itl_victim
  import itl_pkg::*;
#(
  parameter int unsigned WAYS  = WAYS_DEF,
  parameter int unsigned WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  output logic [WAY_W-1:0] victim
);

  localparam int unsigned BYTE_W   = LFSR_W / 2;
  localparam int unsigned TBL_SIZE = 1 << BYTE_W;

  typedef logic [MOD_W-1:0] mod_tbl_t [TBL_SIZE];

  function automatic mod_tbl_t build_mod_tbl();
    mod_tbl_t t;
    for (int i = 0; i < TBL_SIZE; i++) begin
      t[i] = MOD_W'(i % WAYS);
    end
    return t;
  endfunction

  localparam mod_tbl_t         MOD_TBL  = build_mod_tbl();
  localparam logic [MOD_W-1:0] BYTE_MOD = MOD_W'(TBL_SIZE % WAYS);

  logic [LFSR_W-1:0] lfsr;
  logic [LFSR_W-1:0] lfsr_next;
  logic [BYTE_W-1:0] fold;

  // lfsr = hi*256 + lo, so fold the two byte residues and reduce once more
  assign fold = BYTE_W'(MOD_TBL[lfsr[LFSR_W-1:BYTE_W]]) * BYTE_W'(BYTE_MOD)
              + BYTE_W'(MOD_TBL[lfsr[BYTE_W-1:0]]);
  assign victim = WAY_W'(MOD_TBL[fold]);

  assign lfsr_next = (lfsr >> 1) ^ (lfsr[0] ? LFSR_MASK : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      lfsr <= LFSR_SEED;
    end else if (step) begin
      lfsr <= lfsr_next;
    end
  end

endmodule

@@ src/icache_tag_lookup_with_latency_unit.sv @@
// top level: set-associative icache tag array with hit/miss latency model
//
// Each word on the input stream stands for one cycle of the fetch front end and
// yields exactly one word on the output stream. Input word: flush, read_valid
// and fetch address. Output word: read_ready, group_valid and four slot
// addresses (base plus 4*i, zero when no group completes).
// The tag ways live in one ram per way, read with the set of the incoming word
// at accept; the compare stage then compares tags, updates the latency counter
// and the replacement lfsr, and loads the output register when that is free.
// A word is accepted every cycle unless the output stalls, a clearing pass runs
// or a flush sits in the compare stage; a refill written in the same cycle as
// the next word's ram read is forwarded. Reset, and every flush leaving the
// compare stage, starts a pass that clears the valid bits of all ways, one set
// per cycle; no input word is accepted while it runs. When the receiver stalls,
// the output register holds its word and the input side stops one word later.
// A wait of L completes L words later. The user must write the hit and miss
// latencies through the cfg port while the block is idle; it does not enforce this.
module icache_tag_lookup_with_latency_unit
  import itl_pkg::*;
#(
  parameter int unsigned WAYS        = WAYS_DEF,
  parameter int unsigned INDEX_BITS  = INDEX_BITS_DEF,
  parameter int unsigned OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_W-1:0]       s_tdata,   // flush, read_valid, fetch_addr[31:0]
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_W-1:0]      m_tdata,   // read_ready, group_valid, slot_address_0..3
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int unsigned SETS    = 1 << INDEX_BITS;
  localparam int unsigned TAG_W   = ADDR_W - INDEX_BITS - OFFSET_BITS;
  localparam int unsigned ENTRY_W = TAG_W + 1;
  localparam int unsigned WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;

  // configuration
  logic [LAT_W-1:0] hit_lat;
  logic [LAT_W-1:0] miss_lat;

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_lat  <= HIT_LAT_RESET;
      miss_lat <= MISS_LAT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_HIT_LAT:  hit_lat  <= cfg_data;
        CFG_MISS_LAT: miss_lat <= cfg_data;
        default: ;
      endcase
    end
  end

  // input side
  in_word_t               s_word;
  logic                   acc;
  logic                   adv;
  logic [INDEX_BITS-1:0]  in_set;

  assign s_word = in_word_t'(s_tdata);
  assign acc    = s_tvalid & s_tready;
  assign in_set = s_word.fetch_addr[OFFSET_BITS +: INDEX_BITS];

  // compare stage registers
  logic                   s1_valid;
  in_word_t               s1_item;
  logic                   s1_byp_valid;
  logic [WAY_W-1:0]       s1_byp_way;
  logic [TAG_W-1:0]       s1_byp_tag;
  logic [INDEX_BITS-1:0]  s1_set;
  logic [TAG_W-1:0]       s1_tag;

  assign s1_set = s1_item.fetch_addr[OFFSET_BITS +: INDEX_BITS];
  assign s1_tag = s1_item.fetch_addr[ADDR_W-1 -: TAG_W];

  // valid-bit clearing pass
  logic                  clearing;
  logic [INDEX_BITS-1:0] clr_set;

  assign adv      = s1_valid & (~m_tvalid | m_tready);
  assign s_tready = ~clearing & (~s1_valid | (adv & ~s1_item.flush));

  // replacement
  logic             miss_fill;
  logic             wr_fill;
  logic [WAY_W-1:0] victim;

  assign wr_fill = adv & miss_fill;

  itl_victim #(
    .WAYS  (WAYS),
    .WAY_W (WAY_W)
  ) u_victim (
    .clk    (clk),
    .rst    (rst),
    .step   (wr_fill),
    .victim (victim)
  );

  // tag ways: valid bit on top of the tag
  logic [ENTRY_W-1:0]    rd_word [WAYS];
  logic [WAYS-1:0]       way_valid;
  logic [TAG_W-1:0]      way_tag [WAYS];
  logic [INDEX_BITS-1:0] wr_set;
  logic [ENTRY_W-1:0]    wr_word;
  logic                  hit;

  assign wr_set  = clearing ? clr_set : s1_set;
  assign wr_word = clearing ? '0 : {1'b1, s1_tag};

  for (genvar w = 0; w < WAYS; w++) begin : g_way
    logic way_we;
    logic byp_sel;

    assign way_we  = clearing | (wr_fill & (victim == WAY_W'(w)));
    assign byp_sel = s1_byp_valid & (s1_byp_way == WAY_W'(w));

    itl_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (SETS)
    ) u_ram (
      .clk   (clk),
      .we    (way_we),
      .waddr (wr_set),
      .wdata (wr_word),
      .re    (acc),
      .raddr (in_set),
      .rdata (rd_word[w])
    );

    assign way_valid[w] = byp_sel | rd_word[w][TAG_W];
    assign way_tag[w]   = byp_sel ? s1_byp_tag : rd_word[w][TAG_W-1:0];
  end

  always_comb begin
    hit = 1'b0;
    for (int w = 0; w < WAYS; w++) begin
      hit = hit | (way_valid[w] & (way_tag[w] == s1_tag));
    end
  end

  // latency model
  logic              busy;
  logic              busy_next;
  logic [LAT_W-1:0]  wait_count;
  logic [LAT_W-1:0]  wait_count_next;
  logic [LAT_W-1:0]  wait_target;
  logic [LAT_W-1:0]  wait_target_next;
  logic [ADDR_W-1:0] held_address;
  logic [ADDR_W-1:0] held_address_next;
  logic [LAT_W-1:0]  lat;
  logic [ADDR_W-1:0] base;
  out_word_t         res;

  always_comb begin
    busy_next         = busy;
    wait_count_next   = wait_count;
    wait_target_next  = wait_target;
    held_address_next = held_address;
    miss_fill         = 1'b0;
    base              = '0;
    lat               = hit ? hit_lat : miss_lat;
    res               = '0;

    if (s1_item.flush) begin
      busy_next        = 1'b0;
      wait_count_next  = '0;
      wait_target_next = '0;
      res.read_ready   = 1'b1;
    end else if (!busy) begin
      res.read_ready = 1'b1;
      if (s1_item.read_valid) begin
        held_address_next = s1_item.fetch_addr;
        miss_fill         = ~hit;
        wait_target_next  = lat;
        if (lat == '0) begin
          wait_count_next = '0;
          res.group_valid = 1'b1;
          base            = s1_item.fetch_addr;
        end else begin
          busy_next       = 1'b1;
          wait_count_next = LAT_W'(1);
          res.read_ready  = 1'b0;
        end
      end
    end else if (wait_count >= wait_target) begin
      busy_next        = 1'b0;
      wait_count_next  = '0;
      wait_target_next = '0;
      res.read_ready   = 1'b1;
      res.group_valid  = 1'b1;
      base             = held_address;
    end else begin
      wait_count_next = wait_count + 1'b1;
    end

    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (res.group_valid && (i < FETCH_SLOTS)) begin
        res.slot_address[i] = base + ADDR_W'(SLOT_STRIDE * i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      s1_byp_valid <= 1'b0;
      clearing     <= 1'b1;
      clr_set      <= '0;
      busy         <= 1'b0;
      wait_count   <= '0;
      wait_target  <= '0;
      held_address <= '0;
      m_tvalid     <= 1'b0;
    end else begin
      if (acc) begin
        s1_valid     <= 1'b1;
        s1_item      <= s_word;
        // refill landing in the same cycle as this read
        s1_byp_valid <= wr_fill & (s1_set == in_set);
        s1_byp_way   <= victim;
        s1_byp_tag   <= s1_tag;
      end else if (adv) begin
        s1_valid <= 1'b0;
      end

      if (clearing) begin
        clr_set <= clr_set + 1'b1;
        if (clr_set == '1) begin
          clearing <= 1'b0;
        end
      end else if (adv && s1_item.flush) begin
        clearing <= 1'b1;
        clr_set  <= '0;
      end

      if (adv) begin
        busy         <= busy_next;
        wait_count   <= wait_count_next;
        wait_target  <= wait_target_next;
        held_address <= held_address_next;
        m_tvalid     <= 1'b1;
        m_tdata      <= res;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

@@ src/itl_checker.sv @@
// port-level checker for the icache tag lookup, bound to the top level
module itl_checker
  import itl_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             s_tvalid,
  input logic             s_tready,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [OUT_W-1:0] m_tdata
);

  out_word_t ow;

  assign ow = out_word_t'(m_tdata);

  // a stalled word stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output word changed while stalled");

  // a completing group always reports ready
  a_done_ready: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && ow.group_valid |-> ow.read_ready)
    else $error("group_valid without read_ready");

  // no group, no addresses
  a_idle_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !ow.group_valid |-> ow.slot_address == '0)
    else $error("slot address nonzero without group_valid");

  // slot 1 is one word above slot 0
  a_slot_step: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && ow.group_valid |->
      (FETCH_SLOTS < 2) ||
      (ow.slot_address[1] == ow.slot_address[0] + ADDR_W'(SLOT_STRIDE)))
    else $error("slot 1 is not slot 0 plus one word");

  // clearing pass after reset keeps input and output quiet
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_tvalid && !s_tready)
    else $error("activity right after reset");

endmodule

bind icache_tag_lookup_with_latency_unit itl_checker u_itl_checker (.*);

@@ test/tb_top.sv @@
// testbench for the icache tag lookup unit: stream driver, cycle predictor and result checker
`timescale 1ns / 1ps

module tb_top
  import itl_pkg::*;
();

  localparam int unsigned SETS        = 1 << INDEX_BITS_DEF;
  localparam int unsigned TAG_W       = ADDR_W - INDEX_BITS_DEF - OFFSET_BITS_DEF;
  localparam int unsigned NUM_PHASES  = 8;
  localparam longint     CYCLE_LIMIT = 3_000_000;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_W-1:0]       s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_W-1:0]      m_tdata;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_HIT_LAT;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  icache_tag_lookup_with_latency_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // predicted state of the tag array and latency counter
  logic [LAT_W-1:0]  lat_hit = HIT_LAT_RESET;
  logic [LAT_W-1:0]  lat_miss = MISS_LAT_RESET;
  logic [TAG_W-1:0]  tag_mem [WAYS_DEF][SETS];
  logic              line_ok [WAYS_DEF][SETS];
  logic              fe_busy = 1'b0;
  logic [LAT_W-1:0]  wait_cnt = '0;
  logic [LAT_W-1:0]  wait_tgt = '0;
  logic [ADDR_W-1:0] base_addr = '0;
  logic [LFSR_W-1:0] victim_lfsr = LFSR_SEED;

  in_word_t  fetch_words[$];
  out_word_t expected_words[$];
  out_word_t next_expect;

  int     items_made = 0;
  int     items_taken = 0;
  int     results_seen = 0;
  int     errors = 0;
  longint cycle_count = 0;
  bit     idle_on = 1'b1;
  int     gap_left = 0;
  int     stall_left = 0;

  logic [TAG_W-1:0]          hot_tags [6];
  logic [INDEX_BITS_DEF-1:0] hot_sets [3];

  logic [LAT_W-1:0] phase_hit  [NUM_PHASES] = '{10'd1, 10'd0, 10'd1023, 10'd0,
                                                10'd3, 10'd0, 10'd7, 10'd1};
  logic [LAT_W-1:0] phase_miss [NUM_PHASES] = '{10'd10, 10'd0, 10'd1023, 10'd5,
                                                10'd1, 10'd2, 10'd12, 10'd1};
  int phase_items [NUM_PHASES] = '{100, 100, 20, 100, 100, 100, 100, 100};

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic out_word_t group_word(input logic [ADDR_W-1:0] base);
    out_word_t w;
    w = '0;
    w.read_ready  = 1'b1;
    w.group_valid = 1'b1;
    for (int i = 0; i < NUM_SLOTS; i++)
      if (i < FETCH_SLOTS) w.slot_address[i] = base + ADDR_W'(SLOT_STRIDE * i);
    return w;
  endfunction

  // one cycle of the fetch front end
  task automatic predict_fetch_cycle(input in_word_t w, output out_word_t r);
    logic [INDEX_BITS_DEF-1:0] set_i;
    logic [TAG_W-1:0]          tag_i;
    logic                      hit;
    int                        way;
    r = '0;
    if (w.flush) begin
      foreach (line_ok[a, b]) line_ok[a][b] = 1'b0;
      fe_busy  = 1'b0;
      wait_cnt = '0;
      wait_tgt = '0;
      r.read_ready = 1'b1;
    end else if (!fe_busy) begin
      if (!w.read_valid) begin
        r.read_ready = 1'b1;
      end else begin
        base_addr = w.fetch_addr;
        set_i = w.fetch_addr[OFFSET_BITS_DEF +: INDEX_BITS_DEF];
        tag_i = w.fetch_addr[ADDR_W-1 -: TAG_W];
        hit = 1'b0;
        for (int k = 0; k < WAYS_DEF; k++)
          if (line_ok[k][set_i] && tag_mem[k][set_i] == tag_i) hit = 1'b1;
        if (hit) begin
          wait_tgt = lat_hit;
        end else begin
          // victim picked from the lfsr, invalid ways not preferred
          way = int'(victim_lfsr % WAYS_DEF);
          victim_lfsr = victim_lfsr[0] ? ((victim_lfsr >> 1) ^ LFSR_MASK) : (victim_lfsr >> 1);
          tag_mem[way][set_i] = tag_i;
          line_ok[way][set_i] = 1'b1;
          wait_tgt = lat_miss;
        end
        if (wait_tgt == '0) begin
          wait_cnt = '0;
          r = group_word(base_addr);
        end else begin
          fe_busy  = 1'b1;
          wait_cnt = LAT_W'(1);
        end
      end
    end else if (wait_cnt >= wait_tgt) begin
      fe_busy  = 1'b0;
      wait_cnt = '0;
      wait_tgt = '0;
      r = group_word(base_addr);
    end else begin
      wait_cnt = wait_cnt + 1'b1;
    end
  endtask

  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [ADDR_W-1:0] pick_address();
    logic [ADDR_W-1:0] a;
    if ($urandom_range(0, 3) == 0) return $urandom;
    a = $urandom;
    a[ADDR_W-1 -: TAG_W] = hot_tags[$urandom_range(0, 5)];
    a[OFFSET_BITS_DEF +: INDEX_BITS_DEF] = hot_sets[$urandom_range(0, 2)];
    return a;
  endfunction

  task automatic queue_word(input logic flush, input logic rv, input logic [ADDR_W-1:0] addr);
    in_word_t w;
    w = '0;
    w.flush = flush;
    w.read_valid = rv;
    w.fetch_addr = addr;
    fetch_words.push_back(w);
    items_made++;
  endtask

  // feed idle cycles until the lookup has finished, then wait for every result
  task automatic drain_to_idle();
    int extra;
    forever begin
      while (items_taken != items_made) @(negedge clk);
      if (!fe_busy) break;
      extra = int'(wait_tgt) - int'(wait_cnt) + 1;
      repeat (extra) queue_word(1'b0, 1'b0, $urandom);
    end
    while (results_seen != items_made) @(negedge clk);
  endtask

  task automatic set_latencies(input logic [LAT_W-1:0] h, input logic [LAT_W-1:0] m);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_HIT_LAT;
    cfg_data  <= h;
    @(posedge clk);
    cfg_index <= CFG_MISS_LAT;
    cfg_data  <= m;
    @(posedge clk);
    cfg_we    <= 1'b0;
    lat_hit  = h;
    lat_miss = m;
  endtask

  // driver: one word per handshake, prediction at accept
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (s_tvalid && s_tready) begin
        predict_fetch_cycle(in_word_t'(s_tdata), next_expect);
        expected_words.push_back(next_expect);
        items_taken++;
      end
      if (!s_tvalid || s_tready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          s_tvalid <= 1'b0;
        end else if (fetch_words.size() > 0) begin
          s_tdata  <= fetch_words.pop_front();
          s_tvalid <= 1'b1;
          gap_left <= draw_gap();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each result word with the oldest prediction
  always @(posedge clk) begin : monitor
    out_word_t got;
    out_word_t want;
    if (rst) begin
      m_tready   <= 1'b0;
      stall_left <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = out_word_t'(m_tdata);
        results_seen++;
        if (expected_words.size() == 0) begin
          $display("%0t unexpected word: expected none, got %h", $time, m_tdata);
          errors++;
        end else begin
          want = expected_words.pop_front();
          if (got.read_ready !== want.read_ready) begin
            $display("%0t read_ready: expected %0d, got %0d", $time,
                     want.read_ready, got.read_ready);
            errors++;
          end
          if (got.group_valid !== want.group_valid) begin
            $display("%0t group_valid: expected %0d, got %0d", $time,
                     want.group_valid, got.group_valid);
            errors++;
          end
          for (int i = 0; i < NUM_SLOTS; i++)
            if (got.slot_address[i] !== want.slot_address[i]) begin
              $display("%0t slot_address_%0d: expected %h, got %h", $time, i,
                       want.slot_address[i], got.slot_address[i]);
              errors++;
            end
        end
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        m_tready   <= 1'b0;
      end else if (idle_on && $urandom_range(0, 99) < 20) begin
        stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
        m_tready   <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    int r;
    foreach (tag_mem[a, b]) tag_mem[a][b] = '0;
    foreach (line_ok[a, b]) line_ok[a][b] = 1'b0;
    foreach (hot_tags[i]) hot_tags[i] = TAG_W'($urandom);
    foreach (hot_sets[i]) hot_sets[i] = INDEX_BITS_DEF'($urandom);
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: miss, request while busy, hit, eviction, address wrap, flushes
    queue_word(1'b0, 1'b0, 32'h0);
    queue_word(1'b0, 1'b1, 32'h0);
    queue_word(1'b0, 1'b1, 32'hFFFF_FFFF);
    drain_to_idle();
    queue_word(1'b0, 1'b1, 32'h0);
    drain_to_idle();
    queue_word(1'b0, 1'b1, 32'h4);
    drain_to_idle();
    for (int t = 1; t <= 5; t++) begin
      queue_word(1'b0, 1'b1, (t << 10) | (5 << 4));
      drain_to_idle();
    end
    queue_word(1'b0, 1'b1, (1 << 10) | (5 << 4) | 4'hC);
    drain_to_idle();
    queue_word(1'b0, 1'b1, 32'hFFFF_FFFF);
    queue_word(1'b0, 1'b0, 32'h0);
    queue_word(1'b1, 1'b0, 32'h0);
    drain_to_idle();
    queue_word(1'b0, 1'b1, 32'hFFFF_FFFF);
    drain_to_idle();
    queue_word(1'b1, 1'b1, 32'hFFFF_FFF0);
    queue_word(1'b0, 1'b1, 32'hFFFF_FFF0);
    drain_to_idle();

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p > 0) set_latencies(phase_hit[p], phase_miss[p]);
      idle_on = (p != 5);
      for (int n = 0; n < phase_items[p]; n++) begin
        r = $urandom_range(0, 99);
        if (r < 3)
          queue_word(1'b1, 1'($urandom), $urandom);
        else if (r < 63)
          queue_word(1'b0, 1'b1, pick_address());
        else
          queue_word(1'b0, 1'b0, $urandom);
      end
      drain_to_idle();
    end

    repeat (8) @(posedge clk);
    if (expected_words.size() != 0) begin
      $display("%0t leftover predictions: expected 0, got %0d", $time, expected_words.size());
      errors++;
    end
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
src/itl_pkg.sv
src/itl_ram.sv
src/itl_victim.sv
src/icache_tag_lookup_with_latency_unit.sv
src/itl_checker.sv
test/tb_top.sv
